// File: design/lpcp_pkg.sv
// Shared constants, types and helpers of the lidar point camera projector.
package lpcp_pkg;

  localparam int DEF_IMAGE_WIDTH  = 1600;
  localparam int DEF_IMAGE_HEIGHT = 900;
  localparam int NUM_REGS         = 8;
  localparam int REG_IDX_W        = 3;
  localparam int ONE_Q16          = 65536;
  // Quotient bits of u/w and v/w in Q12.4; 16*IMAGE_WIDTH stays below 2**16.
  localparam int QBITS            = 16;
  // Width of a Q16.16 dot product: three 48-bit terms and a 32-bit offset.
  localparam int VAL_W            = 52;
  // Width of the divider remainder: 16*u, with room for the largest shifted divisor.
  localparam int REM_W            = VAL_W + QBITS;

  // Register indexes; each row occupies two consecutive registers.
  localparam logic [REG_IDX_W-1:0] REG_ROW_U = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_V = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_W = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW_D = 3'd6;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] width;
    logic [15:0] height;
  } box_t;

  // Picks one signed Q16.16 coefficient out of a packed register.
  function automatic logic signed [31:0] coef(input logic [63:0] r, input logic upper);
    return upper ? $signed(r[63:32]) : $signed(r[31:0]);
  endfunction

endpackage

// File: design/lpcp_in_if.sv
// Input channel carrying one lidar point and its detection box.
interface lpcp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [15:0] box_center_x;
  logic [15:0] box_center_y;
  logic [15:0] box_width;
  logic [15:0] box_height;

  modport source (output valid, point_x, point_y, point_z, box_center_x, box_center_y,
                  box_width, box_height, input ready);
  modport sink (input valid, point_x, point_y, point_z, box_center_x, box_center_y,
                box_width, box_height, output ready);
endinterface

// File: design/lpcp_out_if.sv
// Output channel carrying one projected pixel and its flags.
interface lpcp_out_if;
  logic        valid;
  logic        ready;
  logic        in_frame;
  logic        in_box;
  logic [14:0] pixel_x;
  logic [13:0] pixel_y;

  modport source (output valid, in_frame, in_box, pixel_x, pixel_y, input ready);
  modport sink (input valid, in_frame, in_box, pixel_x, pixel_y, output ready);
endinterface

// File: design/lpcp_div_step.sv
// One registered restoring-division step producing a single quotient bit.
module lpcp_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [lpcp_pkg::REM_W-1:0]     rem_in,
  input  logic [lpcp_pkg::VAL_W-1:0]     den,
  input  logic [lpcp_pkg::QBITS-1:0]     q_in,
  output logic [lpcp_pkg::REM_W-1:0]     rem_out,
  output logic [lpcp_pkg::QBITS-1:0]     q_out
);
  import lpcp_pkg::*;

  logic [REM_W-1:0] den_sh;

  assign den_sh = REM_W'(den) << SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= den_sh) begin
        rem_out <= rem_in - den_sh;
        q_out   <= q_in | (QBITS'(1) << SHIFT);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end
endmodule

// File: design/lidar_point_camera_projector.sv
// Top level of the lidar point camera projector pipeline.
//
// Each input transaction on pt carries one lidar point (signed Q16.16 metres)
// and a detection box (unsigned Q12.4 pixels). Each produces exactly one
// output transaction on res: the in-frame and in-box flags and the Q12.4
// pixel, which is zero when the point is rejected.
// Software writes the eight 64-bit coefficient registers over the APB port
// (register i at byte address 8*i) while no point is in flight.
// The pipeline has 20 register stages: the coefficient products, the dot
// product sums, the frame test, sixteen divider steps (one quotient bit each
// for u/w and v/w) and the output register. One point is accepted every
// cycle while the receiver does not stall the pipeline; stage 0 holds the
// 32x32 multipliers and each divider step a 68-bit compare-subtract.
// Every stage carries its own valid bit and holds only while it is full and
// the stage after it holds, so bubbles collapse and a stalled receiver stops
// the pipeline without losing or repeating a transaction.
// Synchronous reset clears all valid bits and all coefficient registers.
module lidar_point_camera_projector #(
  parameter int IMAGE_WIDTH  = lpcp_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = lpcp_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  lpcp_in_if.sink     pt,
  lpcp_out_if.source  res
);
  import lpcp_pkg::*;

  // Stage 0 products, 1 sums, 2 frame test, 3..QBITS+2 divider, last output.
  localparam int NS    = QBITS + 4;
  localparam int S_OUT = NS - 1;

  logic [63:0] regs [NUM_REGS];

  // The configuration registers; every address of the port maps to one.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      regs[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = regs[paddr[5:3]];
  assign pready = 1'b1;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  assign en[NS] = res.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pt.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pt.ready  = en[0];
  assign res.valid = vld[S_OUT];

  // Stage 0: twelve coefficient products, three per row.
  logic signed [63:0] prod [12];
  box_t               box0;
  logic [REG_IDX_W-1:0] row_base [4];

  assign row_base[0] = REG_ROW_U;
  assign row_base[1] = REG_ROW_V;
  assign row_base[2] = REG_ROW_W;
  assign row_base[3] = REG_ROW_D;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 4; r++) begin
        prod[3*r]   <= coef(regs[row_base[r]], 1'b0) * $signed(pt.point_x);
        prod[3*r+1] <= coef(regs[row_base[r]], 1'b1) * $signed(pt.point_y);
        prod[3*r+2] <= coef(regs[row_base[r] + 3'd1], 1'b0) * $signed(pt.point_z);
      end
      box0 <= '{center_x: pt.box_center_x, center_y: pt.box_center_y,
                 width: pt.box_width, height: pt.box_height};
    end
  end

  // Stage 1: floor each product to Q16.16 and add the constant column.
  logic signed [VAL_W-1:0] dot [4];
  box_t                    box1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 4; r++) begin
        dot[r] <= VAL_W'(prod[3*r] >>> 16) + VAL_W'(prod[3*r+1] >>> 16)
                + VAL_W'(prod[3*r+2] >>> 16)
                + VAL_W'(coef(regs[row_base[r] + 3'd1], 1'b1));
      end
      box1 <= box0;
    end
  end

  // Stage 2: exact frame test on u, v, w and depth; set up the dividers.
  logic signed [63:0] lim_u;
  logic signed [63:0] lim_v;
  logic               frame_c;

  assign lim_u = $signed(64'(IMAGE_WIDTH)) * 64'(dot[2]);
  assign lim_v = $signed(64'(IMAGE_HEIGHT)) * 64'(dot[2]);
  assign frame_c = (dot[3] >= VAL_W'(ONE_Q16)) && (dot[2] > 0)
                && (dot[0] > 0) && (64'(dot[0]) < lim_u)
                && (dot[1] > 0) && (64'(dot[1]) < lim_v);

  logic [REM_W-1:0] rem_u [QBITS+1];
  logic [REM_W-1:0] rem_v [QBITS+1];
  logic [QBITS-1:0] quo_u [QBITS+1];
  logic [QBITS-1:0] quo_v [QBITS+1];
  logic [VAL_W-1:0] den   [QBITS+1];
  logic             frm   [QBITS+1];
  box_t             boxd  [QBITS+1];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_u[0] <= REM_W'({dot[0], 4'b0000});
      rem_v[0] <= REM_W'({dot[1], 4'b0000});
      quo_u[0] <= '0;
      quo_v[0] <= '0;
      den[0]   <= dot[2];
      frm[0]   <= frame_c;
      boxd[0]  <= box1;
    end
  end

  // Stages 3 and on: one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    lpcp_div_step #(.SHIFT(QBITS - 1 - k)) u_step_u (
      .clk(clk), .en(en[3+k]), .rem_in(rem_u[k]), .den(den[k]), .q_in(quo_u[k]),
      .rem_out(rem_u[k+1]), .q_out(quo_u[k+1])
    );
    lpcp_div_step #(.SHIFT(QBITS - 1 - k)) u_step_v (
      .clk(clk), .en(en[3+k]), .rem_in(rem_v[k]), .den(den[k]), .q_in(quo_v[k]),
      .rem_out(rem_v[k+1]), .q_out(quo_v[k+1])
    );
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        den[k+1]  <= den[k];
        frm[k+1]  <= frm[k];
        boxd[k+1] <= boxd[k];
      end
    end
  end

  // Output stage: box test on the Q12.4 pixel, doubled to keep it exact.
  logic signed [18:0] px2, py2, x_lo, x_hi, y_lo, y_hi;
  logic               box_c;
  box_t               bq;

  assign bq   = boxd[QBITS];
  assign px2  = $signed({2'b00, quo_u[QBITS], 1'b0});
  assign py2  = $signed({2'b00, quo_v[QBITS], 1'b0});
  assign x_lo = $signed({2'b00, bq.center_x, 1'b0}) - $signed({3'b000, bq.width});
  assign x_hi = $signed({2'b00, bq.center_x, 1'b0}) + $signed({3'b000, bq.width});
  assign y_lo = $signed({2'b00, bq.center_y, 1'b0}) - $signed({3'b000, bq.height});
  assign y_hi = $signed({2'b00, bq.center_y, 1'b0}) + $signed({3'b000, bq.height});
  assign box_c = (x_lo < px2) && (px2 < x_hi) && (y_lo < py2) && (py2 < y_hi);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      res.in_frame <= frm[QBITS];
      res.in_box   <= frm[QBITS] && box_c;
      res.pixel_x  <= frm[QBITS] ? quo_u[QBITS][14:0] : 15'd0;
      res.pixel_y  <= frm[QBITS] ? quo_v[QBITS][13:0] : 14'd0;
    end
  end

  // A point inside the box is always inside the frame.
  a_box_in_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!res.in_box || res.in_frame))
    else $error("in_box set without in_frame");

  // A rejected point carries a zero pixel.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.in_frame) |-> (res.pixel_x == 15'd0 && res.pixel_y == 14'd0))
    else $error("rejected point with nonzero pixel");

  // An accepted transaction occupies the first stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (pt.valid && pt.ready) |=> vld[0])
    else $error("accepted transaction lost at pipeline entry");

  // A full pipeline facing a stalled receiver takes no new transaction.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&vld) && !res.ready) |-> !pt.ready)
    else $error("input accepted while pipeline full and stalled");

endmodule
